// ----- src/hsb_to_display_color_assert.svh -----
// Assertion macros for the HSB to display color converter.
// Used by the top level; needs nothing besides the including module's clock and reset.
`ifndef HSB_TO_DISPLAY_COLOR_ASSERT_SVH
`define HSB_TO_DISPLAY_COLOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define HSBDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsb_to_display_color: implication check failed");

// Check that a condition implies another, delayed by the n argument.
`define HSBDC_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("hsb_to_display_color: delayed check failed");

`endif

// ----- src/hsbdc_pkg.sv -----
// Shared types and constants of the HSB to display color converter.
// No dependencies; the top level and every stage module use it.
`timescale 1ns / 1ps
`default_nettype none

package hsbdc_pkg;

   // Fixed-point constants
   localparam int unsigned HUE_FULL      = 23040;   // 360 degrees in 1/64 degree
   localparam int unsigned HUE_SECTOR    = 3840;    // 60 degrees
   localparam int unsigned ONE_Q12       = 4096;    // 1.0 in Q1.12
   localparam int unsigned SECTOR_SPAN   = ONE_Q12 * HUE_SECTOR;
   localparam int unsigned RECIP15       = 2185;    // ceil(2^15 / 15)
   localparam int unsigned RECIP15_SHIFT = 15;
   localparam int unsigned CHAN_MAX      = 255;
   localparam int unsigned DEPTH_MAX     = 8;

   // Register indexes
   localparam logic [2:0] CSR_DISPLAY_READY = 3'd0;
   localparam logic [2:0] CSR_MONOCHROME    = 3'd1;
   localparam logic [2:0] CSR_RED_BITS      = 3'd2;
   localparam logic [2:0] CSR_GREEN_BITS    = 3'd3;
   localparam logic [2:0] CSR_BLUE_BITS     = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_READY = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   // Hue sector, named by the (r,g,b) order of its V, P, Q and A terms
   typedef enum logic [2:0] {
      SECT_VQA   = 3'd0,
      SECT_PVA   = 3'd1,
      SECT_AVQ   = 3'd2,
      SECT_APV   = 3'd3,
      SECT_QAV   = 3'd4,
      SECT_VAP   = 3'd5,
      SECT_BLACK = 3'd6
   } sector_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [12:0] saturation;
      logic [12:0] brightness;
   } req_type;

   typedef struct packed {
      logic [23:0] display_color;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic       display_ready;
      logic       monochrome;
      logic [3:0] red_bits;
      logic [3:0] green_bits;
      logic [3:0] blue_bits;
   } cfg_type;

   // Front stage result: clamped operands and hue split
   typedef struct packed {
      sector_type  sector;
      logic [11:0] frac;
      logic [12:0] sat;
      logic [19:0] bri255;
      logic        grey;
   } front_type;

   // Product stage result: P and Q before the divide by 15, with A and V as bytes
   typedef struct packed {
      sector_type  sector;
      logic [11:0] p_pre;
      logic [11:0] q_pre;
      logic [7:0]  a8;
      logic [7:0]  v8;
      logic        grey;
   } prod_type;

   typedef struct packed {
      logic [7:0] r8;
      logic [7:0] g8;
      logic [7:0] b8;
   } rgb_type;

endpackage

`default_nettype wire

// ----- src/hsb_to_display_color.sv -----
// Top level of the HSB to display color converter: configuration registers and the
// five-stage pipeline. Depends on hsbdc_pkg, the stage modules and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "hsb_to_display_color_assert.svh"

// One request is taken at every clock where start is high; busy never rises. Each
// request gives exactly one result, shown on rsp_data for one cycle with rsp_strobe high,
// in request order. Each request passes through clamp and sector split, two multiplier
// stages, the divide by 15 and channel select, and the pack stage. The receiver cannot
// hold results off, so it must take each one as it comes. Write the configuration
// registers only while no request is in flight; a write is registered first and then
// applies to the results that the pack stage forms.

module hsb_to_display_color (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  hsbdc_pkg::req_type   req_data,
   output logic                 rsp_strobe,
   output hsbdc_pkg::rsp_type   rsp_data,
   input  wire                  csr_write,
   input  wire  [2:0]           csr_index,
   input  wire  [3:0]           csr_wdata
);

   localparam int LATENCY = 5;

   hsbdc_pkg::cfg_type    cfg_ff;
   hsbdc_pkg::cfg_type    cfg_in;
   logic                  req_accept;
   logic                  front_valid;
   hsbdc_pkg::front_type  front_stage;
   logic                  prod_valid;
   hsbdc_pkg::prod_type   prod_stage;
   logic                  rgb_valid;
   hsbdc_pkg::rgb_type    rgb_stage;

   // Never stall the request side
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            hsbdc_pkg::CSR_DISPLAY_READY: cfg_in.display_ready = csr_wdata[0];
            hsbdc_pkg::CSR_MONOCHROME:    cfg_in.monochrome    = csr_wdata[0];
            hsbdc_pkg::CSR_RED_BITS:      cfg_in.red_bits      = csr_wdata;
            hsbdc_pkg::CSR_GREEN_BITS:    cfg_in.green_bits    = csr_wdata;
            hsbdc_pkg::CSR_BLUE_BITS:     cfg_in.blue_bits     = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_ready <= 1'b0;
         cfg_ff.monochrome    <= 1'b0;
         cfg_ff.red_bits      <= 4'd5;
         cfg_ff.green_bits    <= 4'd6;
         cfg_ff.blue_bits     <= 4'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hsbdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (req_accept),
      .req_in    (req_data),
      .valid_out (front_valid),
      .stage_out (front_stage)
   );

   hsbdc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (front_valid),
      .stage_in  (front_stage),
      .valid_out (prod_valid),
      .stage_out (prod_stage)
   );

   hsbdc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (prod_valid),
      .stage_in  (prod_stage),
      .valid_out (rgb_valid),
      .rgb_out   (rgb_stage)
   );

   hsbdc_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (rgb_valid),
      .rgb_in     (rgb_stage),
      .cfg        (cfg_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Every taken request comes out of the pipeline as an rsp_strobe pulse
   `HSBDC_ASSERT_DELAY(a_latency, clock, reset, req_accept, LATENCY, rsp_strobe)

   // A display that is not ready answers not-ready with an empty word
   `HSBDC_ASSERT_IMPLY(a_not_ready, clock, reset, rsp_strobe && !cfg_ff.display_ready, (rsp_data.status == hsbdc_pkg::STATUS_NOT_READY) && (rsp_data.display_color == 24'd0))

   // An invalid color never carries a word
   `HSBDC_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_strobe && (rsp_data.status == hsbdc_pkg::STATUS_INVALID), rsp_data.display_color == 24'd0)

   // Monochrome words use bit zero alone
   `HSBDC_ASSERT_IMPLY(a_mono_bit, clock, reset, rsp_strobe && cfg_ff.monochrome, rsp_data.display_color[23:1] == 23'd0)

endmodule

`default_nettype wire

// ----- src/hsbdc_front.sv -----
// Front stage: clamps saturation and brightness, folds the hue and splits it into sector and
// fraction. Depends on hsbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsbdc_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   valid_in,
   input  hsbdc_pkg::req_type    req_in,
   output logic                  valid_out,
   output hsbdc_pkg::front_type  stage_out
);

   logic [12:0]           sat_clamp;
   logic [12:0]           bri_clamp;
   logic [14:0]           hue_fold;
   logic [14:0]           hue_base;
   hsbdc_pkg::sector_type sector;
   logic [20:0]           bri255_full;
   logic [14:0]           frac_full;
   logic                  valid_ff;
   hsbdc_pkg::front_type  stage_ff;
   hsbdc_pkg::front_type  stage_in;

   // Clamp operands to 1.0 and treat a full turn as zero
   always_comb begin
      sat_clamp = (req_in.saturation > 13'(hsbdc_pkg::ONE_Q12)) ?
                  13'(hsbdc_pkg::ONE_Q12) : req_in.saturation;
      bri_clamp = (req_in.brightness > 13'(hsbdc_pkg::ONE_Q12)) ?
                  13'(hsbdc_pkg::ONE_Q12) : req_in.brightness;
      hue_fold  = (req_in.hue == 15'(hsbdc_pkg::HUE_FULL)) ? 15'd0 : req_in.hue;
   end

   // Locate the sector; anything past a full turn goes black
   always_comb begin
      if (hue_fold < 15'(hsbdc_pkg::HUE_SECTOR)) begin
         sector   = hsbdc_pkg::SECT_VQA;
         hue_base = 15'd0;
      end else if (hue_fold < 15'(2 * hsbdc_pkg::HUE_SECTOR)) begin
         sector   = hsbdc_pkg::SECT_PVA;
         hue_base = 15'(hsbdc_pkg::HUE_SECTOR);
      end else if (hue_fold < 15'(3 * hsbdc_pkg::HUE_SECTOR)) begin
         sector   = hsbdc_pkg::SECT_AVQ;
         hue_base = 15'(2 * hsbdc_pkg::HUE_SECTOR);
      end else if (hue_fold < 15'(4 * hsbdc_pkg::HUE_SECTOR)) begin
         sector   = hsbdc_pkg::SECT_APV;
         hue_base = 15'(3 * hsbdc_pkg::HUE_SECTOR);
      end else if (hue_fold < 15'(5 * hsbdc_pkg::HUE_SECTOR)) begin
         sector   = hsbdc_pkg::SECT_QAV;
         hue_base = 15'(4 * hsbdc_pkg::HUE_SECTOR);
      end else if (hue_fold < 15'(hsbdc_pkg::HUE_FULL)) begin
         sector   = hsbdc_pkg::SECT_VAP;
         hue_base = 15'(5 * hsbdc_pkg::HUE_SECTOR);
      end else begin
         sector   = hsbdc_pkg::SECT_BLACK;
         hue_base = hue_fold;
      end
   end

   // Form 255*B by shift and subtract, and the in-sector fraction
   always_comb begin
      bri255_full       = {bri_clamp, 8'h00} - {8'h00, bri_clamp};
      frac_full         = hue_fold - hue_base;
      stage_in.sector   = sector;
      stage_in.frac     = frac_full[11:0];
      stage_in.sat      = sat_clamp;
      stage_in.bri255   = bri255_full[19:0];
      stage_in.grey     = (req_in.saturation == 13'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ----- src/hsbdc_mult.sv -----
// Product stages: saturation by fraction, then brightness by the sector terms.
// Two register stages; depends on hsbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsbdc_mult (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   valid_in,
   input  hsbdc_pkg::front_type  stage_in,
   output logic                  valid_out,
   output hsbdc_pkg::prod_type   stage_out
);

   // First product stage
   logic [11:0]           frac_rest;
   logic [12:0]           sat_rest;
   logic [24:0]           sf_full;
   logic [24:0]           sfc_full;
   logic [32:0]           ap_full;
   logic [23:0]           sf_ff;
   logic [23:0]           sfc_ff;
   logic [31:0]           ap_ff;
   logic [19:0]           bri255_ff;
   hsbdc_pkg::sector_type sector_ff;
   logic                  grey_ff;
   logic                  valid1_ff;

   // Second product stage
   logic [23:0]           tp;
   logic [23:0]           tq;
   logic [43:0]           xp;
   logic [43:0]           xq;
   hsbdc_pkg::prod_type   prod_in;
   hsbdc_pkg::prod_type   prod_ff;
   logic                  valid2_ff;

   // Multiply saturation by fraction and its complement, and 255*B by 1-S
   always_comb begin
      frac_rest = 12'(hsbdc_pkg::HUE_SECTOR) - stage_in.frac;
      sat_rest  = 13'(hsbdc_pkg::ONE_Q12) - stage_in.sat;
      sf_full   = stage_in.sat * frac_rest;
      sfc_full  = stage_in.sat * stage_in.frac;
      ap_full   = stage_in.bri255 * sat_rest;
   end

   always_ff @(posedge clock) begin
      sfc_ff    <= sf_full[23:0];
      sf_ff     <= sfc_full[23:0];
      ap_ff     <= ap_full[31:0];
      bri255_ff <= stage_in.bri255;
      sector_ff <= stage_in.sector;
      grey_ff   <= stage_in.grey;
   end

   // Scale the sector terms by 255*B and keep the part above 2^32
   always_comb begin
      tp             = 24'(hsbdc_pkg::SECTOR_SPAN) - sf_ff;
      tq             = 24'(hsbdc_pkg::SECTOR_SPAN) - sfc_ff;
      xp             = bri255_ff * tp;
      xq             = bri255_ff * tq;
      prod_in.sector = sector_ff;
      prod_in.p_pre  = xp[43:32];
      prod_in.q_pre  = xq[43:32];
      prod_in.a8     = ap_ff[31:24];
      prod_in.v8     = bri255_ff[19:12];
      prod_in.grey   = grey_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid_in;
         valid2_ff <= valid1_ff;
      end
   end

   assign valid_out = valid2_ff;
   assign stage_out = prod_ff;

endmodule

`default_nettype wire

// ----- src/hsbdc_select.sv -----
// Select stage: finishes the divide by 15 and routes V, P, Q and A to red, green and blue.
// Depends on hsbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsbdc_select (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  valid_in,
   input  hsbdc_pkg::prod_type  stage_in,
   output logic                 valid_out,
   output hsbdc_pkg::rgb_type   rgb_out
);

   logic [23:0]         p_prod;
   logic [23:0]         q_prod;
   logic [7:0]          p8;
   logic [7:0]          q8;
   hsbdc_pkg::rgb_type  rgb_in;
   hsbdc_pkg::rgb_type  rgb_ff;
   logic                valid_ff;

   // Divide by 15 through the reciprocal; exact for quotients below 2^12
   always_comb begin
      p_prod = stage_in.p_pre * 12'(hsbdc_pkg::RECIP15);
      q_prod = stage_in.q_pre * 12'(hsbdc_pkg::RECIP15);
      p8     = p_prod[hsbdc_pkg::RECIP15_SHIFT +: 8];
      q8     = q_prod[hsbdc_pkg::RECIP15_SHIFT +: 8];
   end

   // Route channels by sector; zero saturation gives grey
   always_comb begin
      case (stage_in.sector)
         hsbdc_pkg::SECT_VQA: rgb_in = '{stage_in.v8, q8, stage_in.a8};
         hsbdc_pkg::SECT_PVA: rgb_in = '{p8, stage_in.v8, stage_in.a8};
         hsbdc_pkg::SECT_AVQ: rgb_in = '{stage_in.a8, stage_in.v8, q8};
         hsbdc_pkg::SECT_APV: rgb_in = '{stage_in.a8, p8, stage_in.v8};
         hsbdc_pkg::SECT_QAV: rgb_in = '{q8, stage_in.a8, stage_in.v8};
         hsbdc_pkg::SECT_VAP: rgb_in = '{stage_in.v8, stage_in.a8, p8};
         default:             rgb_in = '{8'd0, 8'd0, 8'd0};
      endcase
      if (stage_in.grey) begin
         rgb_in = '{stage_in.v8, stage_in.v8, stage_in.v8};
      end
   end

   always_ff @(posedge clock) begin
      rgb_ff <= rgb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid_out = valid_ff;
   assign rgb_out   = rgb_ff;

endmodule

`default_nettype wire

// ----- src/hsbdc_pack.sv -----
// Pack stage: drops low bits to the configured depths or encodes black and white,
// and sets the status. Depends on hsbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsbdc_pack (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  valid_in,
   input  hsbdc_pkg::rgb_type   rgb_in,
   input  hsbdc_pkg::cfg_type   cfg,
   output logic                 rsp_strobe,
   output hsbdc_pkg::rsp_type   rsp_data
);

   logic [3:0]          rd;
   logic [3:0]          gd;
   logic [3:0]          bd;
   logic [7:0]          r_pk;
   logic [7:0]          g_pk;
   logic [7:0]          b_pk;
   logic [4:0]          gb_shift;
   logic [23:0]         word;
   logic                is_white;
   logic                is_black;
   hsbdc_pkg::rsp_type  rsp_in;
   hsbdc_pkg::rsp_type  rsp_ff;
   logic                strobe_ff;

   function automatic logic [3:0] clamp_depth(input logic [3:0] d);
      clamp_depth = (d > 4'(hsbdc_pkg::DEPTH_MAX)) ? 4'(hsbdc_pkg::DEPTH_MAX) : d;
   endfunction

   // Keep the top bits of each channel and stack red over green over blue
   always_comb begin
      rd       = clamp_depth(cfg.red_bits);
      gd       = clamp_depth(cfg.green_bits);
      bd       = clamp_depth(cfg.blue_bits);
      r_pk     = rgb_in.r8 >> (4'(hsbdc_pkg::DEPTH_MAX) - rd);
      g_pk     = rgb_in.g8 >> (4'(hsbdc_pkg::DEPTH_MAX) - gd);
      b_pk     = rgb_in.b8 >> (4'(hsbdc_pkg::DEPTH_MAX) - bd);
      gb_shift = {1'b0, gd} + {1'b0, bd};
      word     = (24'(r_pk) << gb_shift) | (24'(g_pk) << bd) | 24'(b_pk);
   end

   // Choose word and status
   always_comb begin
      is_white = (rgb_in.r8 == 8'(hsbdc_pkg::CHAN_MAX)) &&
                 (rgb_in.g8 == 8'(hsbdc_pkg::CHAN_MAX)) &&
                 (rgb_in.b8 == 8'(hsbdc_pkg::CHAN_MAX));
      is_black = (rgb_in.r8 == 8'd0) && (rgb_in.g8 == 8'd0) && (rgb_in.b8 == 8'd0);
      if (!cfg.display_ready) begin
         rsp_in.display_color = 24'd0;
         rsp_in.status        = hsbdc_pkg::STATUS_NOT_READY;
      end else if (cfg.monochrome) begin
         if (is_white || is_black) begin
            rsp_in.display_color = {23'd0, is_white};
            rsp_in.status        = hsbdc_pkg::STATUS_OK;
         end else begin
            rsp_in.display_color = 24'd0;
            rsp_in.status        = hsbdc_pkg::STATUS_INVALID;
         end
      end else begin
         rsp_in.display_color = word;
         rsp_in.status        = hsbdc_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
